### rtl/b64_pkg.sv
// Shared types, constants and character mapping functions for the Base64 codec.
`default_nettype none

package b64_pkg;

  // Storage sizes
  localparam int B64_QUEUE_DEPTH = 4;
  localparam int B64_ACC_W       = 12;
  localparam int B64_CNT_W       = 4;
  localparam int B64_MAX_CHARS   = 4;

  // Character and symbol codes
  localparam logic [7:0] B64_PAD_CHAR = 8'h3D;
  localparam logic [6:0] B64_SYM_PAD  = 7'd64;
  localparam logic [6:0] B64_SYM_BAD  = 7'd65;
  localparam logic       B64_MODE_ENC = 1'b0;

  // One queued work record: up to four result beats from a single input beat
  typedef struct packed {
    logic [B64_MAX_CHARS-1:0][7:0] chars;
    logic [2:0]                    n;
    logic                          last;
    logic                          no_data;
  } b64_rec_t;

  // 6-bit index to alphabet character
  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] c;
    if (idx < 6'd26) begin
      c = 8'h41 + {2'b00, idx};
    end else if (idx < 6'd52) begin
      c = 8'd71 + {2'b00, idx};
    end else if (idx < 6'd62) begin
      c = {2'b00, idx} - 8'd4;
    end else if (idx == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  // Character to symbol value: 0..63 alphabet, pad code, or bad code
  function automatic logic [6:0] b64_sym(input logic [7:0] c);
    logic [7:0] d;
    logic [6:0] v;
    d = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      v = d[6:0];
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'd71;
      v = d[6:0];
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c + 8'd4;
      v = d[6:0];
    end else if (c == 8'h2B) begin
      v = 7'd62;
    end else if (c == 8'h2F) begin
      v = 7'd63;
    end else if (c == B64_PAD_CHAR) begin
      v = B64_SYM_PAD;
    end else begin
      v = B64_SYM_BAD;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/base64_codec.sv
// Top level of the streaming Base64 encoder and decoder.
//
//   Channel  Handshake    Payload
//   input    push / full  in_mode, in_data_in, in_last_in
//   result   empty / pop  out_data_out, out_last_out, out_no_data
//
// An input beat is taken when the record queue has room; it
// yields zero to four result beats. The back end sends one result beat per
// cycle while pop keeps taking them, so throughput is set by the result port.
// First result passes through a queue slot and then the result register
// before it shows on the result ports. Synchronous active-low reset clears
// the accumulator, the queue pointers and count, and the result valid flag.
// Stalls on pop back up into the queue and then raise full.
`default_nettype none

module base64_codec
  import b64_pkg::*;
#(
  parameter int QUEUE_DEPTH = B64_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic       in_mode,
  input  wire logic [7:0] in_data_in,
  input  wire logic       in_last_in,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_data_out,
  output logic            out_last_out,
  output logic            out_no_data
);

  b64_rec_t wr_rec;
  b64_rec_t head_rec;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_has_data;

  assign full = q_full;

  b64_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (push),
    .in_mode  (in_mode),
    .in_data  (in_data_in),
    .in_last  (in_last_in),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_rec    (wr_rec)
  );

  b64_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_rec   (wr_rec),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_rec   (head_rec),
    .has_data (q_has_data)
  );

  b64_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head_rec),
    .has_data (q_has_data),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .data_out (out_data_out),
    .last_out (out_last_out),
    .no_data  (out_no_data)
  );

endmodule

`default_nettype wire

### rtl/b64_front.sv
// Front end: accepts input beats, updates the bit accumulator, builds work records.
`default_nettype none

module b64_front
  import b64_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_mode,
  input  wire logic [7:0] in_data,
  input  wire logic       in_last,
  input  wire logic       q_full,
  output logic            q_push,
  output b64_rec_t        q_rec
);

  logic [B64_ACC_W-1:0] acc_r, acc_nxt;
  logic [B64_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 pad_r, pad_nxt;

  logic                 accept;
  logic                 keep;
  logic [B64_ACC_W-1:0] acc0;
  logic [B64_CNT_W-1:0] cnt0;
  logic [B64_ACC_W-1:0] acc_enc;
  logic [B64_ACC_W-1:0] acc_dec;
  logic [B64_CNT_W-1:0] cnt_dec;
  logic [B64_CNT_W-1:0] shamt;
  logic [B64_ACC_W-1:0] shifted;
  logic [6:0]           sym;

  assign accept = in_valid && !q_full;
  assign sym    = b64_sym(in_data);

  // Encoder keeps only bit counts left by whole bytes
  assign keep    = (cnt_r == 4'd0) || (cnt_r == 4'd2) || (cnt_r == 4'd4);
  assign acc0    = keep ? acc_r : '0;
  assign cnt0    = keep ? cnt_r : '0;
  assign acc_enc = {acc0[3:0], in_data};

  // Decoder accumulator path
  assign acc_dec = {acc_r[5:0], sym[5:0]};
  assign cnt_dec = cnt_r + 4'd6;
  assign shamt   = cnt_dec - 4'd8;
  assign shifted = acc_dec >> shamt;

  // Classify the beat and build its record
  always_comb begin
    acc_nxt         = acc_r;
    cnt_nxt         = cnt_r;
    pad_nxt         = pad_r;
    q_rec.chars     = '0;
    q_rec.n         = 3'd0;
    q_rec.last      = in_last;
    q_rec.no_data   = 1'b0;

    if (in_mode == B64_MODE_ENC) begin
      acc_nxt = acc_enc;
      case (cnt0)
        4'd0: begin
          q_rec.chars[0] = b64_char(acc_enc[7:2]);
          q_rec.n        = 3'd1;
          cnt_nxt        = 4'd2;
          if (in_last) begin
            q_rec.chars[1] = b64_char({acc_enc[1:0], 4'b0000});
            q_rec.chars[2] = B64_PAD_CHAR;
            q_rec.chars[3] = B64_PAD_CHAR;
            q_rec.n        = 3'd4;
          end
        end
        4'd2: begin
          q_rec.chars[0] = b64_char(acc_enc[9:4]);
          q_rec.n        = 3'd1;
          cnt_nxt        = 4'd4;
          if (in_last) begin
            q_rec.chars[1] = b64_char({acc_enc[3:0], 2'b00});
            q_rec.chars[2] = B64_PAD_CHAR;
            q_rec.n        = 3'd3;
          end
        end
        default: begin
          q_rec.chars[0] = b64_char(acc_enc[11:6]);
          q_rec.chars[1] = b64_char(acc_enc[5:0]);
          q_rec.n        = 3'd2;
          cnt_nxt        = 4'd0;
        end
      endcase
    end else begin
      if (!pad_r) begin
        if (sym == B64_SYM_PAD) begin
          pad_nxt = 1'b1;
        end else if (sym < B64_SYM_PAD) begin
          acc_nxt = acc_dec;
          cnt_nxt = cnt_dec;
          if (cnt_dec >= 4'd8) begin
            q_rec.chars[0] = shifted[7:0];
            q_rec.n        = 3'd1;
            cnt_nxt        = shamt;
          end
        end
      end
      // End of message with no byte: marker only
      if (in_last && (q_rec.n == 3'd0)) begin
        q_rec.n       = 3'd1;
        q_rec.no_data = 1'b1;
      end
    end

    // Message end clears all state
    if (in_last) begin
      acc_nxt = '0;
      cnt_nxt = '0;
      pad_nxt = 1'b0;
    end
  end

  assign q_push = accept && (q_rec.n != 3'd0);

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
      pad_r <= 1'b0;
    end else if (accept) begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      pad_r <= pad_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/b64_queue.sv
// Short queue of work records between front and back ends.
`default_nettype none

module b64_queue
  import b64_pkg::*;
#(
  parameter int DEPTH = B64_QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr_en,
  input  wire b64_rec_t  wr_rec,
  output logic           full,
  input  wire logic      rd_en,
  output b64_rec_t       rd_rec,
  output logic           has_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64_rec_t         slots_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign has_data = (count_r != '0);
  assign rd_rec   = slots_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Record storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots_r[wr_ptr_r] <= wr_rec;
    end
  end

endmodule

`default_nettype wire

### rtl/b64_back.sv
// Back end: walks each record one beat at a time into the result register.
`default_nettype none

module b64_back
  import b64_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire b64_rec_t   head,
  input  wire logic       has_data,
  output logic            q_pop,
  input  wire logic       pop,
  output logic            empty,
  output logic [7:0]      data_out,
  output logic            last_out,
  output logic            no_data
);

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       last_r;
  logic       nodata_r;
  logic       load;
  logic       at_end;

  // Load a new beat when the result register is free or being taken
  assign load   = has_data && (!valid_r || pop);
  assign at_end = ({1'b0, idx_r} == (head.n - 3'd1));
  assign q_pop  = load && at_end;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = at_end ? 2'd0 : idx_r + 2'd1;
      valid_nxt = 1'b1;
    end else if (pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      data_r   <= head.chars[idx_r];
      last_r   <= head.last && at_end;
      nodata_r <= head.no_data;
    end
  end

  assign empty    = !valid_r;
  assign data_out = data_r;
  assign last_out = last_r;
  assign no_data  = nodata_r;

endmodule

`default_nettype wire

### rtl/base64_codec_chk.sv
// Port-level checker for the Base64 codec, bound to the top level.
`default_nettype none

module base64_codec_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       push,
  input wire logic       full,
  input wire logic       in_mode,
  input wire logic [7:0] in_data_in,
  input wire logic       in_last_in,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_data_out,
  input wire logic       out_last_out,
  input wire logic       out_no_data
);

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result shown right after reset");

  // Reset leaves room for input
  a_reset_room: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("full raised right after reset");

  // A marker-only beat always closes a message
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_no_data) |-> out_last_out)
    else $error("marker beat without last");

  // A marker-only beat carries a zero byte
  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_no_data) |-> (out_data_out == 8'd0))
    else $error("marker beat with data");

  // A waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data_out) && $stable(out_last_out)
                          && $stable(out_no_data)))
    else $error("waiting result changed");

endmodule

bind base64_codec base64_codec_chk u_chk (.*);

`default_nettype wire
